### rtl/core/boolean_query_lexer_macros.svh
// ---------------------------------------------------------------------------
// boolean_query_lexer_macros
// assertion shorthands used by the lexer queue, clocked on clk, reset rst_n
// ---------------------------------------------------------------------------
`ifndef BOOLEAN_QUERY_LEXER_MACROS_SVH
`define BOOLEAN_QUERY_LEXER_MACROS_SVH

// condition must never hold outside reset
`define BQL_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("boolean_query_lexer assertion failed");

// antecedent implies consequent in the same cycle
`define BQL_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("boolean_query_lexer assertion failed");

// antecedent implies consequent in the next cycle
`define BQL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("boolean_query_lexer assertion failed");

`endif

### rtl/core/bql_pkg.sv
// ---------------------------------------------------------------------------
// bql_pkg
// token types, character codes and helper functions of the query lexer
// ---------------------------------------------------------------------------
`default_nettype none

package bql_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // token kinds
    localparam logic [3:0] KIND_LPAREN = 4'd0;
    localparam logic [3:0] KIND_RPAREN = 4'd1;
    localparam logic [3:0] KIND_AND    = 4'd2;
    localparam logic [3:0] KIND_OR     = 4'd3;
    localparam logic [3:0] KIND_NOT    = 4'd4;
    localparam logic [3:0] KIND_BYTE   = 4'd5;
    localparam logic [3:0] KIND_EMPTY  = 4'd6;
    localparam logic [3:0] KIND_END    = 4'd7;
    localparam logic [3:0] KIND_ERROR  = 4'd8;

    // error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_UNCLOSED = 2'd1;
    localparam logic [1:0] ERR_STRAY    = 2'd2;

    // request types
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_END  = 1'b1;

    // characters
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_UNDER  = 8'h5f;
    localparam logic [7:0] CH_ASCII_MAX = 8'd127;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_D   = 8'h44;
    localparam logic [7:0] CH_UP_N   = 8'h4e;
    localparam logic [7:0] CH_UP_O   = 8'h4f;
    localparam logic [7:0] CH_UP_R   = 8'h52;
    localparam logic [7:0] CH_UP_T   = 8'h54;
    localparam logic [7:0] CH_UP_Z   = 8'h5a;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_N   = 8'h6e;
    localparam logic [7:0] CH_LO_R   = 8'h72;
    localparam logic [7:0] CH_LO_T   = 8'h74;
    localparam logic [7:0] CH_LO_Z   = 8'h7a;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CASE_GAP  = 8'd32;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] tbyte;
        logic       tend;
        logic [1:0] err;
    } tok_t;

    // all tokens caused by one request, last_idx is count minus one
    typedef struct packed {
        tok_t [3:0] tok;
        logic [1:0] last_idx;
    } bundle_t;

    typedef struct packed {
        tok_t [2:0] tok;
        logic [1:0] n;
    } flush_t;

    function automatic tok_t mk_tok(input logic [3:0] kind, input logic [7:0] tbyte,
                                    input logic tend, input logic [1:0] err);
        tok_t t;
        t.kind  = kind;
        t.tbyte = tbyte;
        t.tend  = tend;
        t.err   = err;
        return t;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return ((b >= CH_TAB) && (b <= CH_CR)) || (b == CH_SPACE);
    endfunction

    function automatic logic is_term_byte(input logic [7:0] b);
        return ((b >= CH_0) && (b <= CH_9)) || ((b >= CH_UP_A) && (b <= CH_UP_Z)) ||
               ((b >= CH_LO_A) && (b <= CH_LO_Z)) || (b == CH_UNDER) ||
               (b > CH_ASCII_MAX);
    endfunction

    function automatic logic [7:0] upcase(input logic [7:0] b);
        return ((b >= CH_LO_A) && (b <= CH_LO_Z)) ? (b - CASE_GAP) : b;
    endfunction

    function automatic logic [7:0] unescape(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            CH_LO_N: r = CH_LF;
            CH_LO_T: r = CH_TAB;
            CH_LO_R: r = CH_CR;
            default: r = b;
        endcase
        return r;
    endfunction

    // keyword match or the held bytes of a term, the final one marked
    function automatic flush_t flush_toks(input logic [2:0][7:0] held,
                                          input logic [1:0] cnt, input logic strm);
        flush_t     f;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        a = upcase(held[0]);
        b = upcase(held[1]);
        c = upcase(held[2]);
        f.tok = '0;
        f.n   = 2'd0;
        if (!strm && (cnt == 2'd2) && (a == CH_UP_O) && (b == CH_UP_R)) begin
            f.tok[0] = mk_tok(KIND_OR, 8'd0, 1'b0, ERR_NONE);
            f.n      = 2'd1;
        end else if (!strm && (cnt == 2'd3) && (a == CH_UP_A) && (b == CH_UP_N) &&
                     (c == CH_UP_D)) begin
            f.tok[0] = mk_tok(KIND_AND, 8'd0, 1'b0, ERR_NONE);
            f.n      = 2'd1;
        end else if (!strm && (cnt == 2'd3) && (a == CH_UP_N) && (b == CH_UP_O) &&
                     (c == CH_UP_T)) begin
            f.tok[0] = mk_tok(KIND_NOT, 8'd0, 1'b0, ERR_NONE);
            f.n      = 2'd1;
        end else begin
            for (int i = 0; i < 3; i++) begin
                if (2'(i) < cnt) begin
                    f.tok[i] = mk_tok(KIND_BYTE, held[i], 2'(i + 1) == cnt, ERR_NONE);
                end
            end
            f.n = cnt;
        end
        return f;
    endfunction

endpackage

`default_nettype wire

### rtl/core/bql_front.sv
// ---------------------------------------------------------------------------
// bql_front
// lexer state machine, turns each request into a bundle of up to four tokens
// ---------------------------------------------------------------------------
`default_nettype none

module bql_front
    import bql_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       req_type,
    input  wire logic [7:0] byte_value,
    input  wire logic       q_full,
    output logic            push,
    output bundle_t         push_data
);

    typedef enum logic [4:0] {
        MODE_IDLE  = 5'b00001,
        MODE_TERM  = 5'b00010,
        MODE_QUOTE = 5'b00100,
        MODE_ESC   = 5'b01000,
        MODE_ERR   = 5'b10000
    } mode_t;

    mode_t            mode_reg, mode_next;
    logic             dq_reg, dq_next;
    logic [2:0][7:0]  held_reg, held_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             strm_reg, strm_next;

    logic             fire;
    tok_t [3:0]       toks;
    logic [2:0]       n;
    tok_t             tail;
    logic             has_tail;
    logic             do_idle;
    flush_t           fl;
    logic [7:0]       closer;

    assign in_ready = !q_full;
    assign fire     = in_valid && in_ready;
    assign closer   = dq_reg ? CH_DQUOTE : CH_SQUOTE;

    always_comb
    begin
        mode_next = mode_reg;
        dq_next   = dq_reg;
        held_next = held_reg;
        cnt_next  = cnt_reg;
        strm_next = strm_reg;
        toks      = '0;
        n         = 3'd0;
        tail      = '0;
        has_tail  = 1'b0;
        do_idle   = 1'b0;
        fl        = flush_toks(held_reg, cnt_reg, strm_reg);
        if (fire) begin
            if (req_type == REQ_END) begin
                if (mode_reg == MODE_TERM) begin
                    toks[2:0] = fl.tok;
                    n         = {1'b0, fl.n};
                    tail      = mk_tok(KIND_END, 8'd0, 1'b0, ERR_NONE);
                    has_tail  = 1'b1;
                end else if ((mode_reg == MODE_QUOTE) || (mode_reg == MODE_ESC)) begin
                    tail     = mk_tok(KIND_ERROR, 8'd0, 1'b0, ERR_UNCLOSED);
                    has_tail = 1'b1;
                end else if (mode_reg != MODE_ERR) begin
                    tail     = mk_tok(KIND_END, 8'd0, 1'b0, ERR_NONE);
                    has_tail = 1'b1;
                end
                mode_next = MODE_IDLE;
                cnt_next  = 2'd0;
                strm_next = 1'b0;
            end else begin
                unique case (mode_reg)
                    MODE_ERR:
                    begin
                    end
                    MODE_QUOTE:
                    begin
                        if (byte_value == CH_BSLASH) begin
                            mode_next = MODE_ESC;
                        end else if (byte_value == closer) begin
                            if (cnt_reg == 2'd0) begin
                                tail = mk_tok(KIND_EMPTY, 8'd0, 1'b0, ERR_NONE);
                            end else begin
                                tail = mk_tok(KIND_BYTE, held_reg[0], 1'b1, ERR_NONE);
                            end
                            has_tail  = 1'b1;
                            cnt_next  = 2'd0;
                            strm_next = 1'b0;
                            mode_next = MODE_IDLE;
                        end else begin
                            tail         = mk_tok(KIND_BYTE, held_reg[0], 1'b0, ERR_NONE);
                            has_tail     = (cnt_reg != 2'd0);
                            held_next[0] = byte_value;
                            cnt_next     = 2'd1;
                            strm_next    = 1'b1;
                        end
                    end
                    MODE_ESC:
                    begin
                        tail         = mk_tok(KIND_BYTE, held_reg[0], 1'b0, ERR_NONE);
                        has_tail     = (cnt_reg != 2'd0);
                        held_next[0] = unescape(byte_value);
                        cnt_next     = 2'd1;
                        strm_next    = 1'b1;
                        mode_next    = MODE_QUOTE;
                    end
                    MODE_TERM:
                    begin
                        if (is_term_byte(byte_value)) begin
                            if (strm_reg) begin
                                tail         = mk_tok(KIND_BYTE, held_reg[0], 1'b0, ERR_NONE);
                                has_tail     = 1'b1;
                                held_next[0] = byte_value;
                                cnt_next     = 2'd1;
                            end else if (cnt_reg != 2'd3) begin
                                held_next[cnt_reg] = byte_value;
                                cnt_next           = cnt_reg + 2'd1;
                            end else begin
                                // long term, start streaming the held bytes
                                for (int i = 0; i < 3; i++) begin
                                    toks[i] = mk_tok(KIND_BYTE, held_reg[i], 1'b0, ERR_NONE);
                                end
                                n            = 3'd3;
                                held_next[0] = byte_value;
                                cnt_next     = 2'd1;
                                strm_next    = 1'b1;
                            end
                        end else begin
                            toks[2:0] = fl.tok;
                            n         = {1'b0, fl.n};
                            cnt_next  = 2'd0;
                            strm_next = 1'b0;
                            do_idle   = 1'b1;
                        end
                    end
                    MODE_IDLE:
                    begin
                        do_idle = 1'b1;
                    end
                    default:
                    begin
                        do_idle = 1'b1;
                    end
                endcase

                if (do_idle) begin
                    mode_next = MODE_IDLE;
                    if (is_space(byte_value)) begin
                    end else if (byte_value == CH_LPAREN) begin
                        tail     = mk_tok(KIND_LPAREN, 8'd0, 1'b0, ERR_NONE);
                        has_tail = 1'b1;
                    end else if (byte_value == CH_RPAREN) begin
                        tail     = mk_tok(KIND_RPAREN, 8'd0, 1'b0, ERR_NONE);
                        has_tail = 1'b1;
                    end else if ((byte_value == CH_DQUOTE) || (byte_value == CH_SQUOTE)) begin
                        mode_next = MODE_QUOTE;
                        dq_next   = (byte_value == CH_DQUOTE);
                        cnt_next  = 2'd0;
                        strm_next = 1'b0;
                    end else if (is_term_byte(byte_value)) begin
                        mode_next    = MODE_TERM;
                        held_next[0] = byte_value;
                        cnt_next     = 2'd1;
                        strm_next    = 1'b0;
                    end else begin
                        tail      = mk_tok(KIND_ERROR, 8'd0, 1'b0, ERR_STRAY);
                        has_tail  = 1'b1;
                        mode_next = MODE_ERR;
                    end
                end
            end
        end

        // at most three tokens come before the tail
        if (has_tail) begin
            toks[n[1:0]] = tail;
            n            = n + 3'd1;
        end
    end

    assign push               = fire && (n != 3'd0);
    assign push_data.tok      = toks;
    assign push_data.last_idx = 2'(n - 3'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= MODE_IDLE;
            dq_reg   <= 1'b0;
            cnt_reg  <= 2'd0;
            strm_reg <= 1'b0;
        end else begin
            mode_reg <= mode_next;
            dq_reg   <= dq_next;
            cnt_reg  <= cnt_next;
            strm_reg <= strm_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

endmodule

`default_nettype wire

### rtl/core/bql_queue.sv
// ---------------------------------------------------------------------------
// bql_queue
// short queue of token bundles between the lexer and the output stage
// ---------------------------------------------------------------------------
`default_nettype none

`include "boolean_query_lexer_macros.svh"

module bql_queue
    import bql_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  bundle_t   push_data,
    input  wire logic pop,
    output bundle_t   head,
    output logic      full,
    output logic      empty
);

    bundle_t [QUEUE_DEPTH-1:0] slot_reg;
    logic [QPTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]         count_reg, count_next;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    `BQL_ASSERT_NEVER(a_no_overflow, push && full)
    `BQL_ASSERT_NEVER(a_no_underflow, pop && empty)
    `BQL_ASSERT_NEXT(a_drain_to_empty, (count_reg == QCNT_W'(1)) && pop && !push, empty)

endmodule

`default_nettype wire

### rtl/core/bql_back.sv
// ---------------------------------------------------------------------------
// bql_back
// output stage, walks each bundle one token per cycle into the output register while the output is not stalled
// ---------------------------------------------------------------------------
`default_nettype none

module bql_back
    import bql_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  bundle_t   head,
    input  wire logic q_empty,
    output logic      pop,
    output logic      out_valid,
    input  wire logic out_ready,
    output tok_t      out_tok,
    output logic      out_last
);

    logic       valid_reg;
    tok_t       tok_reg;
    logic       last_reg;
    logic [1:0] idx_reg, idx_next;
    logic       load;
    logic       at_last;

    assign load    = !q_empty && (!valid_reg || out_ready);
    assign at_last = (idx_reg == head.last_idx);
    assign pop     = load && at_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (load) begin
            idx_next = at_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            idx_reg <= idx_next;
            if (load) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            tok_reg  <= head.tok[idx_reg];
            last_reg <= at_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_tok   = tok_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire

### rtl/core/boolean_query_lexer.sv
// ---------------------------------------------------------------------------
// boolean_query_lexer
// tokenizer for boolean search queries, one query byte per request
// ---------------------------------------------------------------------------
// A request is taken every cycle while the four-entry bundle queue is not full;
// one that causes n tokens (up to four, when a held term or keyword is flushed)
// holds the output side longer, since the output register drains one token a
// cycle from that queue while m_tready allows, and the input stalls only once
// that queue fills. Each token passes through the bundle queue and then the
// output register. Term bytes go out one request late so the final byte can
// carry term_end. Tokens sent before an error token are not withdrawn.
`default_nettype none

module boolean_query_lexer
    import bql_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] byte_value
    input  wire logic        s_tuser,   // [0] req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] term_byte, [8] term_end, [10:9] error_code
    output logic [3:0]       m_tuser,   // [3:0] token_kind
    output logic             m_tlast
);

    logic    push;
    logic    pop;
    logic    q_full;
    logic    q_empty;
    bundle_t push_data;
    bundle_t head;
    tok_t    out_tok;

    bql_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .req_type   (s_tuser),
        .byte_value (s_tdata),
        .q_full     (q_full),
        .push       (push),
        .push_data  (push_data)
    );

    bql_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    bql_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_empty   (q_empty),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tok   (out_tok),
        .out_last  (m_tlast)
    );

    assign m_tdata = {5'b0, out_tok.err, out_tok.tend, out_tok.tbyte};
    assign m_tuser = out_tok.kind;

endmodule

`default_nettype wire

### bench/query_token_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// query_token_checker
// watches the request and token streams of the query lexer, predicts the
// tokens of every accepted request and compares them in order
// ---------------------------------------------------------------------------

module query_token_checker
    import bql_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] byte_value
    input  wire logic        s_tuser,   // [0] req_type
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,   // [7:0] term_byte, [8] term_end, [10:9] error_code
    input  wire logic [3:0]  m_tuser,   // [3:0] token_kind
    input  wire logic        m_tlast,
    output int               mismatches,
    output int               tokens_owed
);

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_WORD,
        SCAN_QUOTED,
        SCAN_ESCAPE,
        SCAN_SKIP
    } scan_mode_e;

    typedef struct packed {
        tok_t tok;
        logic last;
    } owed_token_t;

    scan_mode_e   mode;
    logic         dq_open;
    logic [7:0]   held [3];
    int unsigned  held_n;
    logic         streaming;
    tok_t         step_toks [$];
    owed_token_t  owed_q [$];
    owed_token_t  want;
    int           bad_count;

    function automatic logic is_word_char(input logic [7:0] b);
        return b[7] || (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") ||
               (b >= "a" && b <= "z") || (b == "_");
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] b);
        return (b >= "a" && b <= "z") ? (b & 8'hdf) : b;
    endfunction

    task automatic emit_tok(input logic [3:0] kind, input logic [7:0] tbyte,
                            input logic tend, input logic [1:0] err);
        tok_t t;
        t.kind  = kind;
        t.tbyte = tbyte;
        t.tend  = tend;
        t.err   = err;
        step_toks = {step_toks, t};
    endtask

    // held word goes out as a keyword or as its bytes, the final one marked
    task automatic flush_word();
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        a = fold_case(held[0]);
        b = fold_case(held[1]);
        c = fold_case(held[2]);
        if (!streaming && held_n == 2 && a == "O" && b == "R")
            emit_tok(KIND_OR, 8'd0, 1'b0, ERR_NONE);
        else if (!streaming && held_n == 3 && a == "A" && b == "N" && c == "D")
            emit_tok(KIND_AND, 8'd0, 1'b0, ERR_NONE);
        else if (!streaming && held_n == 3 && a == "N" && b == "O" && c == "T")
            emit_tok(KIND_NOT, 8'd0, 1'b0, ERR_NONE);
        else
            for (int i = 0; i < held_n; i++)
                emit_tok(KIND_BYTE, held[i], (i + 1) == held_n, ERR_NONE);
        held_n    = 0;
        streaming = 1'b0;
    endtask

    task automatic quoted_byte(input logic [7:0] b);
        if (held_n != 0)
            emit_tok(KIND_BYTE, held[0], 1'b0, ERR_NONE);
        held[0]   = b;
        held_n    = 1;
        streaming = 1'b1;
    endtask

    task automatic start_token(input logic [7:0] b);
        mode = SCAN_IDLE;
        if ((b >= CH_TAB && b <= CH_CR) || b == CH_SPACE) begin
            // whitespace between tokens
        end else if (b == CH_LPAREN) begin
            emit_tok(KIND_LPAREN, 8'd0, 1'b0, ERR_NONE);
        end else if (b == CH_RPAREN) begin
            emit_tok(KIND_RPAREN, 8'd0, 1'b0, ERR_NONE);
        end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
            mode      = SCAN_QUOTED;
            dq_open   = (b == CH_DQUOTE);
            held_n    = 0;
            streaming = 1'b0;
        end else if (is_word_char(b)) begin
            mode      = SCAN_WORD;
            held[0]   = b;
            held_n    = 1;
            streaming = 1'b0;
        end else begin
            emit_tok(KIND_ERROR, 8'd0, 1'b0, ERR_STRAY);
            mode = SCAN_SKIP;
        end
    endtask

    task automatic predict_tokens(input logic rtype, input logic [7:0] b);
        logic [7:0]  closer;
        owed_token_t e;
        step_toks.delete();
        if (rtype == REQ_END) begin
            case (mode)
                SCAN_WORD: begin
                    flush_word();
                    emit_tok(KIND_END, 8'd0, 1'b0, ERR_NONE);
                end
                SCAN_QUOTED, SCAN_ESCAPE: emit_tok(KIND_ERROR, 8'd0, 1'b0, ERR_UNCLOSED);
                SCAN_SKIP: ;
                default: emit_tok(KIND_END, 8'd0, 1'b0, ERR_NONE);
            endcase
            mode      = SCAN_IDLE;
            held_n    = 0;
            streaming = 1'b0;
        end else begin
            case (mode)
                SCAN_SKIP: ;
                SCAN_QUOTED: begin
                    closer = dq_open ? CH_DQUOTE : CH_SQUOTE;
                    if (b == CH_BSLASH) begin
                        mode = SCAN_ESCAPE;
                    end else if (b == closer) begin
                        if (held_n == 0)
                            emit_tok(KIND_EMPTY, 8'd0, 1'b0, ERR_NONE);
                        else
                            emit_tok(KIND_BYTE, held[0], 1'b1, ERR_NONE);
                        held_n    = 0;
                        streaming = 1'b0;
                        mode      = SCAN_IDLE;
                    end else begin
                        quoted_byte(b);
                    end
                end
                SCAN_ESCAPE: begin
                    if (b == CH_LO_N)
                        quoted_byte(CH_LF);
                    else if (b == CH_LO_T)
                        quoted_byte(CH_TAB);
                    else if (b == CH_LO_R)
                        quoted_byte(CH_CR);
                    else
                        quoted_byte(b);
                    mode = SCAN_QUOTED;
                end
                SCAN_WORD: begin
                    if (!is_word_char(b)) begin
                        flush_word();
                        start_token(b);
                    end else if (streaming) begin
                        emit_tok(KIND_BYTE, held[0], 1'b0, ERR_NONE);
                        held[0] = b;
                        held_n  = 1;
                    end else if (held_n < 3) begin
                        held[held_n] = b;
                        held_n++;
                    end else begin
                        // fourth byte: no keyword possible, release the held three
                        for (int i = 0; i < 3; i++)
                            emit_tok(KIND_BYTE, held[i], 1'b0, ERR_NONE);
                        held[0]   = b;
                        held_n    = 1;
                        streaming = 1'b1;
                    end
                end
                default: start_token(b);
            endcase
        end
        foreach (step_toks[i]) begin
            e.tok  = step_toks[i];
            e.last = (i == step_toks.size() - 1);
            owed_q = {owed_q, e};
        end
    endtask

    task automatic check_token();
        if (owed_q.size() == 0) begin
            bad_count++;
            if (bad_count <= 10)
                $display("checker: unexpected token kind %0d byte %h end %0b err %0d last %0b",
                         m_tuser, m_tdata[7:0], m_tdata[8], m_tdata[10:9], m_tlast);
        end else begin
            want = owed_q.pop_front();
            if (m_tuser !== want.tok.kind || m_tdata[7:0] !== want.tok.tbyte ||
                m_tdata[8] !== want.tok.tend || m_tdata[10:9] !== want.tok.err ||
                m_tlast !== want.last) begin
                bad_count++;
                if (bad_count <= 10)
                    $display({"checker: token mismatch, expected kind %0d byte %h end %0b ",
                              "err %0d last %0b, got kind %0d byte %h end %0b err %0d last %0b"},
                             want.tok.kind, want.tok.tbyte, want.tok.tend, want.tok.err,
                             want.last, m_tuser, m_tdata[7:0], m_tdata[8], m_tdata[10:9],
                             m_tlast);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode      = SCAN_IDLE;
            dq_open   = 1'b0;
            held      = '{default: 8'h00};
            held_n    = 0;
            streaming = 1'b0;
            owed_q.delete();
            bad_count = 0;
            mismatches  <= 0;
            tokens_owed <= 0;
        end else begin
            if (s_tvalid && s_tready)
                predict_tokens(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                check_token();
            mismatches  <= bad_count;
            tokens_owed <= owed_q.size();
        end
    end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// drives query bytes and end-of-query requests into the lexer with random
// bursts, stalls the token side, and reports the checker's verdict
// ---------------------------------------------------------------------------

module tb;
    import bql_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 11;
    localparam int LIMIT_CYCLES  = 60000;
    localparam int HOLD_CYCLES   = 200;
    localparam int HOLD_AT_ITEM  = 40;
    localparam int DRAIN_CYCLES  = 16;
    localparam int RANDOM_ITEMS  = 110;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    int          mismatches;
    int          tokens_owed;
    int          cycle_count;
    int          burst_left;
    int          sent_count;
    logic        hold_request;

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    boolean_query_lexer u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    query_token_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .tokens_owed (tokens_owed)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // one request; the sender may idle between random bursts
    task automatic send_req(input logic rtype, input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rtype;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        burst_left--;
        sent_count++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_req(REQ_BYTE, s[i]);
    endtask

    function automatic logic [7:0] rand_word_byte();
        logic [7:0] b;
        case ($urandom_range(0, 4))
            0: b = CH_0 + 8'($urandom_range(0, 9));
            1: b = CH_UP_A + 8'($urandom_range(0, 25));
            2: b = CH_LO_A + 8'($urandom_range(0, 25));
            3: b = CH_UNDER;
            default: b = 8'($urandom_range(128, 255));
        endcase
        return b;
    endfunction

    task automatic send_keyword();
        string      kw;
        logic [7:0] c;
        case ($urandom_range(0, 2))
            0: kw = "AND";
            1: kw = "OR";
            default: kw = "NOT";
        endcase
        for (int i = 0; i < kw.len(); i++)
        begin
            c = kw[i];
            if ($urandom_range(0, 1) == 1)
                c = c | 8'h20;
            send_req(REQ_BYTE, c);
        end
    endtask

    task automatic send_quoted(input logic closed);
        logic [7:0] q;
        logic [7:0] c;
        int         len;
        q   = ($urandom_range(0, 1) == 1) ? CH_DQUOTE : CH_SQUOTE;
        len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 5);
        send_req(REQ_BYTE, q);
        repeat (len)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                send_req(REQ_BYTE, CH_BSLASH);
                case ($urandom_range(0, 5))
                    0: c = CH_LO_N;
                    1: c = CH_LO_T;
                    2: c = CH_LO_R;
                    3: c = CH_BSLASH;
                    4: c = q;
                    default: c = 8'($urandom_range(0, 255));
                endcase
            end
            else
            begin
                do
                    c = 8'($urandom_range(0, 255));
                while (c == q || c == CH_BSLASH);
            end
            send_req(REQ_BYTE, c);
        end
        if (closed)
            send_req(REQ_BYTE, q);
        else if ($urandom_range(0, 1) == 1)
            send_req(REQ_BYTE, CH_BSLASH);
    endtask

    // mostly well-formed queries; some end in an open quote, a stray byte or noise
    task automatic send_query();
        logic [7:0] c;
        int         n;
        repeat ($urandom_range(1, 6))
        begin
            case ($urandom_range(0, 9))
                0: send_req(REQ_BYTE, CH_LPAREN);
                1: send_req(REQ_BYTE, CH_RPAREN);
                2, 3: send_keyword();
                4, 5: repeat ($urandom_range(1, 3)) send_req(REQ_BYTE, rand_word_byte());
                6: repeat ($urandom_range(4, 9)) send_req(REQ_BYTE, rand_word_byte());
                7, 8: send_quoted(1'b1);
                default:
                begin
                    // keyword with a tail, so it no longer matches
                    send_keyword();
                    send_req(REQ_BYTE, rand_word_byte());
                end
            endcase
            if ($urandom_range(0, 3) != 0)
            begin
                n = $urandom_range(0, 5);
                send_req(REQ_BYTE, (n == 5) ? CH_SPACE : CH_TAB + 8'(n));
            end
        end
        case ($urandom_range(0, 9))
            7: send_quoted(1'b0);
            8:
            begin
                do
                    c = 8'($urandom_range(0, 127));
                while ((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE || c == CH_LPAREN ||
                       c == CH_RPAREN || c == CH_DQUOTE || c == CH_SQUOTE ||
                       (c >= CH_0 && c <= CH_9) || (c >= CH_UP_A && c <= CH_UP_Z) ||
                       (c >= CH_LO_A && c <= CH_LO_Z) || c == CH_UNDER);
                send_req(REQ_BYTE, c);
                repeat ($urandom_range(0, 3)) send_req(REQ_BYTE, 8'($urandom_range(0, 255)));
            end
            9: repeat ($urandom_range(1, 6)) send_req(REQ_BYTE, 8'($urandom_range(0, 255)));
            default: ;
        endcase
        send_req(REQ_END, 8'($urandom_range(0, 255)));
    endtask

    // token side: changing stall styles, plus one long hold-off
    initial
    begin
        int style;
        int style_left;
        int tick;
        int hold_left;
        logic hold_spent;
        style_left = 0;
        tick       = 0;
        hold_spent = 1'b0;
        m_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_request && !hold_spent)
            begin
                hold_spent = 1'b1;
                m_tready <= 1'b0;
                for (hold_left = HOLD_CYCLES; hold_left > 0; hold_left--)
                    @(posedge clk);
            end
            else
            begin
                if (style_left == 0)
                begin
                    style      = $urandom_range(0, 3);
                    style_left = $urandom_range(8, 60);
                end
                style_left--;
                tick++;
                case (style)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) == 0);
                    2: m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= (tick % 5 != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin
        rst_n        <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= 8'h00;
        s_tuser      <= REQ_BYTE;
        hold_request <= 1'b0;
        burst_left   = 0;
        sent_count   = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // parens and all three keywords in mixed case
        send_text("(aNd");
        send_req(REQ_BYTE, CH_TAB);
        send_text("Or)nOT");
        send_req(REQ_END, 8'hff);
        // empty quote, escapes, adjacent term streamed with high bytes, stray byte
        send_text("\"\"'\\n\"'c");
        send_req(REQ_BYTE, 8'hff);
        send_req(REQ_BYTE, 8'h80);
        send_text("_");
        send_req(REQ_BYTE, 8'h00);
        send_text("x");
        send_req(REQ_END, 8'h00);
        // unclosed quote
        send_text("'");
        send_req(REQ_END, 8'h5a);

        while (sent_count < RANDOM_ITEMS)
        begin
            send_query();
            if (sent_count >= HOLD_AT_ITEM)
                hold_request <= 1'b1;
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (tokens_owed != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && tokens_owed == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/bql_pkg.sv
rtl/core/bql_front.sv
rtl/core/bql_queue.sv
rtl/core/bql_back.sv
rtl/core/boolean_query_lexer.sv
bench/query_token_checker.sv
bench/tb.sv
